### sv/bpa_pkg.sv
// Shared types, codes and a helper function for the buddy page allocator.
`default_nettype none

package bpa_pkg;

  localparam int PAGE_CNT_W = 11;
  localparam int OFFSET_W   = 10;
  localparam int EXP_W      = 4;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_TOO_BIG  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DOWN,
    S_MARK,
    S_UP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  mode;
    logic [PAGE_CNT_W-1:0] page_count;
    logic [OFFSET_W-1:0]   block_offset;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [OFFSET_W-1:0]   granted_offset;
    logic [PAGE_CNT_W-1:0] granted_pages;
    logic [PAGE_CNT_W-1:0] avail_pages;
  } rsp_t;

  // mode codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // exponent of the power of two that a nonzero count rounds up to
  function automatic logic [EXP_W-1:0] ceil_log2(input logic [PAGE_CNT_W-1:0] c);
    logic [PAGE_CNT_W-1:0] m;
    logic [EXP_W-1:0]      r;
    m = c - 1'b1;
    r = '0;
    for (int i = 0; i < PAGE_CNT_W; i++) begin
      if (m[i]) r = EXP_W'(i + 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/bpa_chan_if.sv
// Valid/ready channel interface carrying one payload per beat.
`default_nettype none

interface bpa_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/buddy_page_allocator_core.sv
// Buddy page allocator: longest-free-block tree over LEAVES pages.
//
// in_ch carries one request per beat (mode, page_count, block_offset);
// out_ch returns exactly one result beat per request (status,
// granted_offset, granted_pages, avail_pages). Requests are handled one at
// a time; in_ch.ready is high only while the sequencer is idle.
// An allocate walks down the tree one level per cycle (one memory read
// each), marks the node, then walks back up one level per cycle (read the
// sibling, write the parent). A free goes straight to its node and only
// walks up; a rejected request does neither.
// After reset a clearing pass over nodes 1 to 2*LEAVES-1 loads every
// node with its subtree size; no request is taken meanwhile.
// Results sit in an output register: if out_ch is stalled, the next request
// is still accepted and processed, and it waits at completion until the
// register empties.
`default_nettype none

module buddy_page_allocator_core #(
  parameter int LEAVES = 1024
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bpa_chan_if.sink   in_ch,
  bpa_chan_if.source out_ch
);

  localparam int LVL = $clog2(LEAVES);
  localparam int IW  = LVL + 1;
  localparam int VW  = LVL + 1;

  logic          res_valid, res_ready;
  bpa_pkg::rsp_t res;
  logic          out_valid_r;
  bpa_pkg::rsp_t out_data_r;

  logic          mem_wr_en, mem_rd_en;
  logic [IW-1:0] mem_wr_addr, mem_rd_addr;
  logic [VW-1:0] mem_wr_data, mem_rd_data;

  bpa_ctrl #(.LEAVES(LEAVES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_ch.valid),
    .req_ready   (in_ch.ready),
    .req         (in_ch.payload),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  bpa_tree_mem #(.AW(IW), .DW(VW)) u_tree_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

endmodule

`default_nettype wire

### sv/bpa_tree_mem.sv
// Tree node memory: one write port, one read port, registered read data.
`default_nettype none

module bpa_tree_mem #(
  parameter int AW = 11,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/bpa_ctrl.sv
// Sequencer: clearing pass, tree descent, node mark and ancestor update.
`default_nettype none

module bpa_ctrl #(
  parameter  int LEAVES = 1024,
  localparam int LVL    = $clog2(LEAVES),
  localparam int IW     = LVL + 1,
  localparam int VW     = LVL + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bpa_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output bpa_pkg::rsp_t      res,
  output logic               mem_wr_en,
  output logic      [IW-1:0] mem_wr_addr,
  output logic      [VW-1:0] mem_wr_data,
  output logic               mem_rd_en,
  output logic      [IW-1:0] mem_rd_addr,
  input  wire logic [VW-1:0] mem_rd_data
);

  localparam int LW   = $clog2(LVL + 1);
  localparam int CMPW = (VW > bpa_pkg::PAGE_CNT_W) ? VW : bpa_pkg::PAGE_CNT_W;
  localparam logic [IW-1:0] ROOT     = IW'(1);
  localparam logic [IW-1:0] LAST_IDX = {IW{1'b1}};

  bpa_pkg::state_t  state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic             too_big_r, too_big_nxt;
  logic [bpa_pkg::EXP_W-1:0]      exp_r, exp_nxt;
  logic [bpa_pkg::PAGE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LVL-1:0]   off_r, off_nxt;
  logic [VW-1:0]    size_r, size_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [LW-1:0]    d_r, d_nxt;
  logic [VW-1:0]    cur_r, cur_nxt;
  logic [VW-1:0]    fc_r, fc_nxt;
  logic [VW-1:0]    root_r;
  bpa_pkg::status_t status_r, status_nxt;
  logic [bpa_pkg::OFFSET_W-1:0] goff_r, goff_nxt;
  logic [IW-1:0]    clr_idx_r;
  logic [VW-1:0]    clr_size_r;

  logic [bpa_pkg::PAGE_CNT_W-1:0] cnt_in;
  logic [bpa_pkg::EXP_W-1:0]      exp_in;
  logic [LW-1:0]    k_lvl;
  logic             alloc_fail, at_target, clr_last;
  logic [IW-1:0]    child, parent, leaf_idx, off_full;
  logic [LW-1:0]    d_dec, d_inc;
  logic [VW-1:0]    psize, mark_val, up_val, max_val;
  logic [VW:0]      pair_sum, fc_sum;

  assign cnt_in   = (req.page_count == '0) ? bpa_pkg::PAGE_CNT_W'(1) : req.page_count;
  assign exp_in   = bpa_pkg::ceil_log2(cnt_in);
  assign k_lvl    = LW'(exp_r);
  assign at_target = (d_r == k_lvl);
  assign alloc_fail = (CMPW'(cnt_r) > CMPW'(fc_r)) || (root_r < size_r);
  assign clr_last = (clr_idx_r == LAST_IDX);

  // descent picks the left child when it can hold the block
  assign child    = (mem_rd_data >= size_r) ? (idx_r << 1) : ((idx_r << 1) | IW'(1));
  assign d_dec    = d_r - LW'(1);
  assign d_inc    = d_r + LW'(1);
  assign parent   = idx_r >> 1;
  assign leaf_idx = {1'b1, off_r} >> exp_r;
  assign off_full = idx_r << d_r;
  assign mark_val = (mode_r == bpa_pkg::MODE_FREE) ? size_r : '0;
  assign psize    = VW'(1) << d_inc;
  assign max_val  = (cur_r > mem_rd_data) ? cur_r : mem_rd_data;
  assign pair_sum = {1'b0, cur_r} + {1'b0, mem_rd_data};
  // two wholly free buddies merge on free
  assign up_val   = ((mode_r == bpa_pkg::MODE_FREE) && (pair_sum == {1'b0, psize}))
                    ? psize : max_val;
  assign fc_sum   = {1'b0, fc_r} + {1'b0, size_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::S_CLEAR: if (clr_last) state_nxt = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE:  if (req_valid) state_nxt = bpa_pkg::S_CHECK;
      bpa_pkg::S_CHECK: begin
        priority if (too_big_r) state_nxt = bpa_pkg::S_DONE;
        else if (mode_r == bpa_pkg::MODE_FREE) state_nxt = bpa_pkg::S_MARK;
        else if (alloc_fail) state_nxt = bpa_pkg::S_DONE;
        else if (at_target) state_nxt = bpa_pkg::S_MARK;
        else state_nxt = bpa_pkg::S_DOWN;
      end
      bpa_pkg::S_DOWN:  if (d_dec == k_lvl) state_nxt = bpa_pkg::S_MARK;
      bpa_pkg::S_MARK:  state_nxt = (idx_r == ROOT) ? bpa_pkg::S_DONE : bpa_pkg::S_UP;
      bpa_pkg::S_UP:    if (parent == ROOT) state_nxt = bpa_pkg::S_DONE;
      bpa_pkg::S_DONE:  if (res_ready) state_nxt = bpa_pkg::S_IDLE;
      default:          state_nxt = bpa_pkg::S_CLEAR;
    endcase
  end

  // outputs: handshakes and memory ports
  always_comb begin
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_idx_r;
    mem_wr_data = clr_size_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = child << 1;
    unique case (state_r)
      bpa_pkg::S_CLEAR: mem_wr_en = 1'b1;
      bpa_pkg::S_IDLE:  req_ready = 1'b1;
      bpa_pkg::S_CHECK: begin
        mem_rd_en   = !too_big_r && (mode_r == bpa_pkg::MODE_ALLOC) && !alloc_fail
                      && !at_target;
        mem_rd_addr = IW'(2);
      end
      bpa_pkg::S_DOWN: mem_rd_en = (d_dec != k_lvl);
      bpa_pkg::S_MARK: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = mark_val;
        mem_rd_en   = (idx_r != ROOT);
        mem_rd_addr = idx_r ^ IW'(1);
      end
      bpa_pkg::S_UP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = parent;
        mem_wr_data = up_val;
        mem_rd_en   = (parent != ROOT);
        mem_rd_addr = parent ^ IW'(1);
      end
      bpa_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.status         = status_r;
    res.granted_offset = goff_r;
    res.granted_pages  = (status_r == bpa_pkg::STAT_OK)
                         ? bpa_pkg::PAGE_CNT_W'(size_r) : '0;
    res.avail_pages    = bpa_pkg::PAGE_CNT_W'(fc_r);
  end

  // datapath
  always_comb begin
    mode_nxt    = mode_r;
    too_big_nxt = too_big_r;
    exp_nxt     = exp_r;
    cnt_nxt     = cnt_r;
    off_nxt     = off_r;
    size_nxt    = size_r;
    idx_nxt     = idx_r;
    d_nxt       = d_r;
    cur_nxt     = cur_r;
    fc_nxt      = fc_r;
    status_nxt  = status_r;
    goff_nxt    = goff_r;
    unique case (state_r)
      bpa_pkg::S_IDLE: begin
        mode_nxt    = req.mode;
        cnt_nxt     = cnt_in;
        exp_nxt     = exp_in;
        too_big_nxt = int'(exp_in) > LVL;
        off_nxt     = LVL'(req.block_offset);
        size_nxt    = VW'(1) << exp_in;
        idx_nxt     = ROOT;
        d_nxt       = LW'(LVL);
        status_nxt  = bpa_pkg::STAT_OK;
        goff_nxt    = '0;
      end
      bpa_pkg::S_CHECK: begin
        priority if (too_big_r) begin
          status_nxt = bpa_pkg::STAT_TOO_BIG;
        end else if (mode_r == bpa_pkg::MODE_FREE) begin
          idx_nxt = leaf_idx;
          d_nxt   = k_lvl;
        end else if (alloc_fail) begin
          status_nxt = bpa_pkg::STAT_NO_SPACE;
        end
      end
      bpa_pkg::S_DOWN: begin
        idx_nxt = child;
        d_nxt   = d_dec;
      end
      bpa_pkg::S_MARK: begin
        cur_nxt = mark_val;
        if (mode_r == bpa_pkg::MODE_FREE) begin
          fc_nxt = (fc_sum > (VW + 1)'(LEAVES)) ? VW'(LEAVES) : fc_sum[VW-1:0];
        end else begin
          fc_nxt   = (fc_r >= size_r) ? fc_r - size_r : '0;
          goff_nxt = bpa_pkg::OFFSET_W'(off_full[LVL-1:0]);
        end
      end
      bpa_pkg::S_UP: begin
        cur_nxt = up_val;
        idx_nxt = parent;
        d_nxt   = d_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bpa_pkg::S_CLEAR;
      clr_idx_r  <= ROOT;
      clr_size_r <= VW'(LEAVES);
      fc_r       <= VW'(LEAVES);
      root_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      if (state_r == bpa_pkg::S_CLEAR) begin
        clr_idx_r <= clr_idx_r + IW'(1);
        // size halves after the last node of each level
        if (((clr_idx_r + IW'(1)) & clr_idx_r) == '0) begin
          clr_size_r <= clr_size_r >> 1;
        end
      end
      if (mem_wr_en && (mem_wr_addr == ROOT)) begin
        root_r <= mem_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    too_big_r <= too_big_nxt;
    exp_r     <= exp_nxt;
    cnt_r     <= cnt_nxt;
    off_r     <= off_nxt;
    size_r    <= size_nxt;
    idx_r     <= idx_nxt;
    d_r       <= d_nxt;
    cur_r     <= cur_nxt;
    status_r  <= status_nxt;
    goff_r    <= goff_nxt;
  end

endmodule

`default_nettype wire

### sv/bpa_checker.sv
// Port-level checks for the buddy page allocator, bound to the top level.
`default_nettype none

module bpa_checker #(
  parameter int LEAVES = 1024
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire bpa_pkg::rsp_t out_payload
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result beat changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_payload.status != bpa_pkg::STAT_OK) |->
      (out_payload.granted_pages == '0) && (out_payload.granted_offset == '0))
    else $error("failed request reports a grant");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_payload.avail_pages) <= LEAVES))
    else $error("free page count above pool size");

endmodule

bind buddy_page_allocator_core bpa_checker #(.LEAVES(LEAVES)) u_bpa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

`default_nettype wire

### dv/buddy_page_allocator_core_test.sv
// Self-checking testbench for the buddy page allocator core: directed table plus random traffic.
`timescale 1ns / 1ps

module buddy_page_allocator_core_test;

  localparam int LEAVES     = 1024;
  localparam int IDLE_LIMIT = 12000;
  localparam int PHASES     = 4;
  localparam int PHASE_REQS = 350;
  localparam int ALLOC_BIAS [PHASES] = '{70, 50, 35, 60};
  localparam int GAP_MAX    [PHASES] = '{0, 6, 30, 12};

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_STALLY} rx_style_t;

  typedef struct {
    bpa_pkg::req_t rq;
    bit            typed;
    bpa_pkg::rsp_t rs;
  } plan_row_t;

  typedef struct {
    int unsigned off;
    int unsigned pages;
  } block_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpa_chan_if #(.payload_t(bpa_pkg::req_t)) in_ch ();
  bpa_chan_if #(.payload_t(bpa_pkg::rsp_t)) out_ch ();

  logic          tx_valid = 1'b0;
  bpa_pkg::req_t tx_req = '0;
  logic          rx_ready = 1'b0;

  assign in_ch.valid   = tx_valid;
  assign in_ch.payload = tx_req;
  assign out_ch.ready  = rx_ready;

  buddy_page_allocator_core #(.LEAVES(LEAVES)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predicted allocator state
  logic [bpa_pkg::PAGE_CNT_W-1:0] largest_free [1:2*LEAVES-1];
  int unsigned                    free_pg;

  bpa_pkg::rsp_t awaited_rsp [$];
  block_t        held_blocks [$];

  int mismatches   = 0;
  int checked      = 0;
  int n_alloc_ok   = 0;
  int n_free_ok    = 0;
  int n_no_space   = 0;
  int n_too_big    = 0;
  int burst_left   = 0;
  int tx_gap_max   = 0;
  int rx_hold      = 0;
  int idle_cycles  = 0;
  rx_style_t rx_style = RX_CHOPPY;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Runs one request against the predicted tree and returns its result.
  task automatic apply_request(input bpa_pkg::req_t rq, output bpa_pkg::rsp_t rs);
    int unsigned cnt, sz, nsz, idx, lv, rv;
    cnt = rq.page_count;
    if (cnt == 0) cnt = 1;
    sz = 1;
    while (sz < cnt) sz <<= 1;
    rs = '0;
    rs.status = bpa_pkg::STAT_OK;
    if (sz > LEAVES) begin
      rs.status = bpa_pkg::STAT_TOO_BIG;
    end else if (rq.mode == bpa_pkg::MODE_ALLOC) begin
      if (cnt > free_pg || largest_free[1] < sz) begin
        rs.status = bpa_pkg::STAT_NO_SPACE;
      end else begin
        idx = 1;
        for (nsz = LEAVES; nsz != sz; nsz >>= 1)
          idx = (largest_free[2*idx] >= sz) ? 2*idx : 2*idx + 1;
        largest_free[idx] = '0;
        rs.granted_offset = bpa_pkg::OFFSET_W'(idx * nsz - LEAVES);
        while (idx > 1) begin
          idx >>= 1;
          lv = largest_free[2*idx];
          rv = largest_free[2*idx+1];
          largest_free[idx] = bpa_pkg::PAGE_CNT_W'((lv > rv) ? lv : rv);
        end
        rs.granted_pages = bpa_pkg::PAGE_CNT_W'(sz);
        free_pg = (free_pg >= sz) ? free_pg - sz : 0;
      end
    end else begin
      idx = LEAVES + rq.block_offset % LEAVES;
      nsz = 1;
      while (nsz != sz) begin
        idx >>= 1;
        nsz <<= 1;
      end
      largest_free[idx] = bpa_pkg::PAGE_CNT_W'(nsz);
      idx >>= 1;
      nsz <<= 1;
      // buddies that are both wholly free merge into the parent
      while (idx != 0) begin
        lv = largest_free[2*idx];
        rv = largest_free[2*idx+1];
        largest_free[idx] =
          bpa_pkg::PAGE_CNT_W'((lv + rv == nsz) ? nsz : ((lv > rv) ? lv : rv));
        idx >>= 1;
        nsz <<= 1;
      end
      rs.granted_pages = bpa_pkg::PAGE_CNT_W'(sz);
      free_pg = (free_pg + sz > LEAVES) ? LEAVES : free_pg + sz;
    end
    rs.avail_pages = bpa_pkg::PAGE_CNT_W'(free_pg);
  endtask

  // Drives one request in the current burst, waits for the beat, then books it.
  task automatic send_request(input bpa_pkg::req_t rq, input bit typed,
                              input bpa_pkg::rsp_t typed_rs);
    bpa_pkg::rsp_t pred;
    int            gap;
    int unsigned   base, sz;
    if (burst_left == 0) begin
      gap = $urandom_range(tx_gap_max, 0);
      burst_left = $urandom_range(12, 1);
      if (gap != 0) begin
        tx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tx_valid <= 1'b1;
    tx_req   <= rq;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(rq, pred);
    awaited_rsp.push_back(typed ? typed_rs : pred);
    case (pred.status)
      bpa_pkg::STAT_NO_SPACE: n_no_space++;
      bpa_pkg::STAT_TOO_BIG:  n_too_big++;
      default: begin
        if (rq.mode == bpa_pkg::MODE_ALLOC) begin
          n_alloc_ok++;
          held_blocks.push_back('{pred.granted_offset, pred.granted_pages});
        end else begin
          n_free_ok++;
          sz   = pred.granted_pages;
          base = rq.block_offset & ~(sz - 1);
          for (int i = held_blocks.size() - 1; i >= 0; i--)
            if (held_blocks[i].off < base + sz && base < held_blocks[i].off + held_blocks[i].pages)
              held_blocks.delete(i);
        end
      end
    endcase
  endtask

  function automatic plan_row_t typed_row(logic m, int c, int o, bpa_pkg::status_t st,
                                          int go, int gp, int fp);
    plan_row_t r;
    r.rq.mode           = m;
    r.rq.page_count     = bpa_pkg::PAGE_CNT_W'(c);
    r.rq.block_offset   = bpa_pkg::OFFSET_W'(o);
    r.typed             = 1'b1;
    r.rs.status         = st;
    r.rs.granted_offset = bpa_pkg::OFFSET_W'(go);
    r.rs.granted_pages  = bpa_pkg::PAGE_CNT_W'(gp);
    r.rs.avail_pages    = bpa_pkg::PAGE_CNT_W'(fp);
    return r;
  endfunction

  function automatic plan_row_t open_row(logic m, int c, int o);
    plan_row_t r;
    r = typed_row(m, c, o, bpa_pkg::STAT_OK, 0, 0, 0);
    r.typed = 1'b0;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    bpa_pkg::rsp_t want, got;
    if (rst_n && out_ch.valid && rx_ready) begin
      got = out_ch.payload;
      if (awaited_rsp.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat %p", got));
      end else begin
        want = awaited_rsp.pop_front();
        checked++;
        if (got.status != want.status)
          flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.granted_offset != want.granted_offset)
          flag_mismatch($sformatf("granted_offset %0d, want %0d",
                                  got.granted_offset, want.granted_offset));
        if (got.granted_pages != want.granted_pages)
          flag_mismatch($sformatf("granted_pages %0d, want %0d",
                                  got.granted_pages, want.granted_pages));
        if (got.avail_pages != want.avail_pages)
          flag_mismatch($sformatf("avail_pages %0d, want %0d",
                                  got.avail_pages, want.avail_pages));
      end
    end
  end

  // result-side back-pressure
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_style)
        RX_OPEN: rx_ready <= 1'b1;
        RX_CHOPPY: begin
          rx_ready <= 1'($urandom_range(1, 0));
          rx_hold  <= $urandom_range(2, 0);
        end
        default: begin
          // long stalls, short open windows
          rx_ready <= !rx_ready;
          rx_hold  <= rx_ready ? $urandom_range(30, 0) : $urandom_range(4, 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((tx_valid && in_ch.ready) || (out_ch.valid && rx_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, awaited_rsp.size());
      $display("buddy_page_allocator_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    plan_row_t     plan [$];
    bpa_pkg::req_t rq;
    block_t        b;
    bpa_pkg::rsp_t none;
    int unsigned   nsz, roll, k;

    none = '0;
    nsz = LEAVES;
    for (int i = 1; i < 2 * LEAVES; i++) begin
      largest_free[i] = bpa_pkg::PAGE_CNT_W'(nsz);
      if (((i + 1) & i) == 0) nsz >>= 1;
    end
    free_pg = LEAVES;

    plan = {
      typed_row(bpa_pkg::MODE_ALLOC, 1024, 0,    bpa_pkg::STAT_OK,       0, 1024, 0),
      typed_row(bpa_pkg::MODE_ALLOC, 1,    0,    bpa_pkg::STAT_NO_SPACE, 0, 0,    0),
      typed_row(bpa_pkg::MODE_FREE,  1024, 0,    bpa_pkg::STAT_OK,       0, 1024, 1024),
      typed_row(bpa_pkg::MODE_ALLOC, 1025, 0,    bpa_pkg::STAT_TOO_BIG,  0, 0,    1024),
      typed_row(bpa_pkg::MODE_FREE,  2047, 1023, bpa_pkg::STAT_TOO_BIG,  0, 0,    1024),
      typed_row(bpa_pkg::MODE_ALLOC, 0,    0,    bpa_pkg::STAT_OK,       0, 1,    1023),
      open_row(bpa_pkg::MODE_ALLOC,  3,    0),
      open_row(bpa_pkg::MODE_ALLOC,  2,    0),
      open_row(bpa_pkg::MODE_ALLOC,  1,    0),
      open_row(bpa_pkg::MODE_FREE,   3,    5),      // misaligned offset
      open_row(bpa_pkg::MODE_FREE,   4,    4),      // double free
      open_row(bpa_pkg::MODE_FREE,   4,    0),      // frees over live blocks
      open_row(bpa_pkg::MODE_ALLOC,  512,  1023),
      open_row(bpa_pkg::MODE_ALLOC,  513,  0),
      open_row(bpa_pkg::MODE_ALLOC,  1023, 0),
      open_row(bpa_pkg::MODE_FREE,   1,    1023),
      open_row(bpa_pkg::MODE_FREE,   0,    1023),
      open_row(bpa_pkg::MODE_ALLOC,  512,  0),
      open_row(bpa_pkg::MODE_ALLOC,  512,  0),
      open_row(bpa_pkg::MODE_FREE,   512,  'h2AA),
      open_row(bpa_pkg::MODE_ALLOC,  2047, 'h3FF),
      typed_row(bpa_pkg::MODE_FREE,  1024, 'h155, bpa_pkg::STAT_OK,      0, 1024, 1024),
      typed_row(bpa_pkg::MODE_ALLOC, 1024, 0,     bpa_pkg::STAT_OK,      0, 1024, 0),
      typed_row(bpa_pkg::MODE_FREE,  1024, 0,     bpa_pkg::STAT_OK,      0, 1024, 1024)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    tx_gap_max = 3;
    foreach (plan[i])
      send_request(plan[i].rq, plan[i].typed, plan[i].rs);

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_gap_max = GAP_MAX[ph];
      rx_style   = (ph == 0) ? RX_OPEN : (ph == 2) ? RX_STALLY : RX_CHOPPY;
      for (int n = 0; n < PHASE_REQS; n++) begin
        rq.mode         = bpa_pkg::MODE_ALLOC;
        rq.block_offset = bpa_pkg::OFFSET_W'($urandom);
        roll = $urandom_range(99, 0);
        if (roll < 10) begin
          case ($urandom_range(4, 0))
            0: rq.page_count = bpa_pkg::PAGE_CNT_W'($urandom);
            1: begin
              rq.mode       = bpa_pkg::MODE_FREE;
              rq.page_count = bpa_pkg::PAGE_CNT_W'($urandom);
            end
            2: begin
              rq.mode       = bpa_pkg::MODE_FREE;
              rq.page_count = bpa_pkg::PAGE_CNT_W'($urandom_range(8, 1));
            end
            3: begin
              rq.mode       = $urandom_range(1, 0) ? bpa_pkg::MODE_FREE
                                                   : bpa_pkg::MODE_ALLOC;
              rq.page_count = '0;
            end
            default: begin
              if (held_blocks.size() != 0) begin
                b = held_blocks[$urandom_range(held_blocks.size() - 1, 0)];
                rq.mode         = bpa_pkg::MODE_FREE;
                rq.page_count   = bpa_pkg::PAGE_CNT_W'(b.pages);
                rq.block_offset =
                  bpa_pkg::OFFSET_W'(b.off + $urandom_range(b.pages - 1, 0));
              end else begin
                rq.page_count = bpa_pkg::PAGE_CNT_W'($urandom_range(LEAVES, 1));
              end
            end
          endcase
        end else if (held_blocks.size() == 0 || roll < 10 + ALLOC_BIAS[ph] * 9 / 10) begin
          k = $urandom_range(99, 0);
          if (k < 70)
            rq.page_count = bpa_pkg::PAGE_CNT_W'($urandom_range(16, 1));
          else if (k < 92)
            rq.page_count = bpa_pkg::PAGE_CNT_W'($urandom_range(128, 17));
          else
            rq.page_count = bpa_pkg::PAGE_CNT_W'($urandom_range(LEAVES, 129));
        end else begin
          // return a live block, count anywhere that rounds to its size
          b = held_blocks[$urandom_range(held_blocks.size() - 1, 0)];
          rq.mode         = bpa_pkg::MODE_FREE;
          rq.block_offset = bpa_pkg::OFFSET_W'(b.off);
          rq.page_count   = bpa_pkg::PAGE_CNT_W'((b.pages == 1) ? 1 :
                                                 $urandom_range(b.pages, b.pages / 2 + 1));
        end
        send_request(rq, 1'b0, none);
      end
    end

    tx_valid <= 1'b0;
    rx_style = RX_CHOPPY;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("requests: %0d allocs granted, %0d frees, %0d no-space, %0d oversized",
             n_alloc_ok, n_free_ok, n_no_space, n_too_big);
    $display("results checked: %0d, mismatches: %0d", checked, mismatches);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("buddy_page_allocator_core_test OK");
    end else begin
      $display("buddy_page_allocator_core_test NOT OK");
    end
    $finish;
  end

endmodule
